[hw/rtl/swd_pkg.sv]
package swd_pkg;

    // Field widths
    localparam int IDX_W       = 4;
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int THR_W       = 12;
    localparam int THR_SQ_W    = 2 * THR_W;
    localparam int DIGIT_W     = 4;
    localparam int MAG_SQ_W    = 2 * COORD_W;
    localparam int DIST_SQ_W   = MAG_SQ_W + 1;
    localparam int SUM_SQ_W    = 2 * DIFF_W;

    // Defaults
    localparam int TOUCH_SLOTS_DEF = 16;
    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(32);
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(32 * 32);

    // Per-slot tracker state
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TRACK = 2'd1,
        MODE_USED  = 2'd2
    } mode_t;

    // Keypad-style direction codes
    localparam logic [DIGIT_W-1:0] DIGIT_NONE       = 4'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_DOWN_LEFT  = 4'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_DOWN       = 4'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_DOWN_RIGHT = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_LEFT       = 4'd4;
    localparam logic [DIGIT_W-1:0] DIGIT_CENTER     = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_RIGHT      = 4'd6;
    localparam logic [DIGIT_W-1:0] DIGIT_UP_LEFT    = 4'd7;
    localparam logic [DIGIT_W-1:0] DIGIT_UP         = 4'd8;
    localparam logic [DIGIT_W-1:0] DIGIT_UP_RIGHT   = 4'd9;

    // Swipe decision handed from the classifier to the tracker
    typedef struct packed {
        logic                 hit;
        logic [DIGIT_W-1:0]   digit;
    } swd_dir_t;

endpackage

[hw/rtl/swipe_direction_detector_top.sv]
// A word accepted into the input register is classified into the result register.
// Throughput: one word per cycle unless the output stalls; the slot state
// read-modify-write and the three parallel squarers sit in the single stage
// between input and result registers. Reset: all slots idle, frame flag clear,
// threshold 32; start points are not cleared and are only used after being written.
module swipe_direction_detector_top
    import swd_pkg::*;
#(
    parameter int TOUCH_SLOTS = TOUCH_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [THR_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [IDX_W-1:0]     touch_index,
    input  logic                 first_of_frame,
    input  logic                 pressed,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIGIT_W-1:0]   keypad_digit
);

    localparam int SLOT_W = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

    logic [THR_SQ_W-1:0]  thr_sq_reg;
    logic                 a_valid_reg;
    logic [IDX_W-1:0]     a_idx_reg;
    logic                 a_first_reg;
    logic                 a_pressed_reg;
    logic [COORD_W-1:0]   a_x_reg;
    logic [COORD_W-1:0]   a_y_reg;
    logic                 out_valid_reg;
    logic [DIGIT_W-1:0]   digit_reg;
    logic [DIGIT_W-1:0]   digit_next;
    logic                 found_reg;
    logic                 found_next;
    mode_t                mode_reg [TOUCH_SLOTS];
    mode_t                mode_cur;
    mode_t                mode_next;

    logic                 in_accept;
    logic                 out_free;
    logic                 a_adv;
    logic                 found_eff;
    logic                 in_range;
    logic                 active;
    logic                 start_wr;
    logic [SLOT_W-1:0]    a_slot;
    logic [SLOT_W-1:0]    in_slot;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    swd_dir_t             dir;

    // Handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign a_adv     = a_valid_reg && out_free;
    assign in_ready  = !a_valid_reg || out_free;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign keypad_digit = digit_reg;

    assign a_slot  = SLOT_W'(a_idx_reg);
    assign in_slot = SLOT_W'(touch_index);

    // Hold the squared threshold; square it on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg <= THR_SQ_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_sq_reg <= THR_SQ_W'(cfg_wr_data) * THR_SQ_W'(cfg_wr_data);
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_idx_reg     <= touch_index;
            a_first_reg   <= first_of_frame;
            a_pressed_reg <= pressed;
            a_x_reg       <= pos_x;
            a_y_reg       <= pos_y;
        end
    end

    // Start points, read when a word is accepted
    swd_start_mem #(
        .TOUCH_SLOTS (TOUCH_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_start_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (start_wr),
        .wr_addr (a_slot),
        .wr_x    (a_x_reg),
        .wr_y    (a_y_reg),
        .rd_en   (in_accept),
        .rd_addr (in_slot),
        .rd_x    (start_x),
        .rd_y    (start_y)
    );

    // Distance and direction
    swd_classify u_classify (
        .cur_x   (a_x_reg),
        .cur_y   (a_y_reg),
        .start_x (start_x),
        .start_y (start_y),
        .thr_sq  (thr_sq_reg),
        .dir     (dir)
    );

    // Frame gate and slot range
    assign found_eff = a_first_reg ? 1'b0 : found_reg;
    assign in_range  = 32'(a_idx_reg) < TOUCH_SLOTS;
    assign active    = !found_eff && in_range;
    assign mode_cur  = in_range ? mode_reg[a_slot] : MODE_IDLE;

    // Next slot mode
    always_comb
    begin
        mode_next = mode_cur;
        case (mode_cur)
            MODE_TRACK:
            begin
                if (!a_pressed_reg)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (dir.hit)
                begin
                    mode_next = MODE_USED;
                end
            end
            MODE_USED:
            begin
                if (!a_pressed_reg)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                if (a_pressed_reg)
                begin
                    mode_next = MODE_TRACK;
                end
            end
        endcase
    end

    // Outputs of the slot machine
    always_comb
    begin
        digit_next = DIGIT_NONE;
        start_wr   = 1'b0;
        case (mode_cur)
            MODE_TRACK:
            begin
                if (active && a_pressed_reg && dir.hit)
                begin
                    digit_next = dir.digit;
                end
            end
            MODE_USED:
            begin
                digit_next = DIGIT_NONE;
            end
            default:
            begin
                start_wr = a_adv && active && a_pressed_reg;
            end
        endcase
        found_next = found_eff || (digit_next != DIGIT_NONE);
    end

    // Advance slot modes and the frame flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOUCH_SLOTS; i++)
            begin
                mode_reg[i] <= MODE_IDLE;
            end
            found_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            if (active)
            begin
                mode_reg[a_slot] <= mode_next;
            end
            found_reg <= found_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            digit_reg <= digit_next;
        end
    end

`ifndef ASSERT_OFF
    // A reported swipe closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && (digit_next != DIGIT_NONE) |=> found_reg)
        else $error("frame flag not set after swipe");

    // A closed frame reports nothing until the next frame starts
    assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && found_reg && !a_first_reg |-> digit_next == DIGIT_NONE)
        else $error("swipe reported in closed frame");

    // A used touch never reports a second swipe
    assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && (mode_cur == MODE_USED) |-> digit_next == DIGIT_NONE)
        else $error("used touch reported a swipe");

    // Only keypad direction codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (digit_reg <= DIGIT_UP_RIGHT) && (digit_reg != DIGIT_CENTER))
        else $error("invalid direction code");

    // The start point is written only for a slot leaving idle
    assert property (@(posedge clk) disable iff (!rst_n)
        start_wr |-> (mode_next == MODE_TRACK) && a_adv)
        else $error("start write outside press");
`endif

endmodule

[hw/rtl/swd_start_mem.sv]
module swd_start_mem
    import swd_pkg::*;
#(
    parameter int TOUCH_SLOTS = TOUCH_SLOTS_DEF,
    parameter int SLOT_W      = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [SLOT_W-1:0]    wr_addr,
    input  logic [COORD_W-1:0]   wr_x,
    input  logic [COORD_W-1:0]   wr_y,
    input  logic                 rd_en,
    input  logic [SLOT_W-1:0]    rd_addr,
    output logic [COORD_W-1:0]   rd_x,
    output logic [COORD_W-1:0]   rd_y
);

    logic [2*COORD_W-1:0] mem [TOUCH_SLOTS];
    logic [2*COORD_W-1:0] rd_data_reg;
    logic [2*COORD_W-1:0] fwd_data_reg;
    logic                 fwd_sel_reg;

    // Write the start point of a newly pressed touch
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_x, wr_y};
        end
    end

    // Read on accept; capture the word written in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= {wr_x, wr_y};
        end
    end

    // Select the bypass when the read hits the slot being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_sel_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_sel_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_x = fwd_sel_reg ? fwd_data_reg[2*COORD_W-1:COORD_W] : rd_data_reg[2*COORD_W-1:COORD_W];
    assign rd_y = fwd_sel_reg ? fwd_data_reg[COORD_W-1:0] : rd_data_reg[COORD_W-1:0];

endmodule

[hw/rtl/swd_classify.sv]
module swd_classify
    import swd_pkg::*;
(
    input  logic [COORD_W-1:0]   cur_x,
    input  logic [COORD_W-1:0]   cur_y,
    input  logic [COORD_W-1:0]   start_x,
    input  logic [COORD_W-1:0]   start_y,
    input  logic [THR_SQ_W-1:0]  thr_sq,
    output swd_dir_t             dir
);

    logic [DIFF_W-1:0]    dx;
    logic [DIFF_W-1:0]    dy;
    logic [COORD_W-1:0]   ax;
    logic [COORD_W-1:0]   ay;
    logic [DIFF_W-1:0]    sum;
    logic [MAG_SQ_W-1:0]  ax_sq;
    logic [MAG_SQ_W-1:0]  ay_sq;
    logic [SUM_SQ_W-1:0]  sum_sq;
    logic [DIST_SQ_W-1:0] dist_sq;
    logic                 horiz;
    logic                 vert;
    logic                 dx_pos;
    logic                 dy_neg;

    // Displacement and magnitudes (fit in 16 bits unsigned)
    assign dx = {cur_x[COORD_W-1], cur_x} - {start_x[COORD_W-1], start_x};
    assign dy = {cur_y[COORD_W-1], cur_y} - {start_y[COORD_W-1], start_y};
    assign ax = dx[DIFF_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    assign ay = dy[DIFF_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    assign sum = DIFF_W'(ax) + DIFF_W'(ay);

    // Three independent squarers
    assign ax_sq  = MAG_SQ_W'(ax) * MAG_SQ_W'(ax);
    assign ay_sq  = MAG_SQ_W'(ay) * MAG_SQ_W'(ay);
    assign sum_sq = SUM_SQ_W'(sum) * SUM_SQ_W'(sum);

    // Distance test and sector tests
    assign dist_sq = DIST_SQ_W'(ax_sq) + DIST_SQ_W'(ay_sq);
    assign horiz   = sum_sq < SUM_SQ_W'({ax_sq, 1'b0});
    assign vert    = sum_sq < SUM_SQ_W'({ay_sq, 1'b0});
    assign dx_pos  = !dx[DIFF_W-1] && (dx != '0);
    assign dy_neg  = dy[DIFF_W-1];

    // Pick the sector code
    always_comb
    begin
        dir.hit = dist_sq >= DIST_SQ_W'(thr_sq);
        if ((ax == '0) && (ay == '0))
        begin
            dir.digit = DIGIT_RIGHT;
        end
        else if (horiz)
        begin
            dir.digit = dx_pos ? DIGIT_RIGHT : DIGIT_LEFT;
        end
        else if (vert)
        begin
            dir.digit = dy_neg ? DIGIT_UP : DIGIT_DOWN;
        end
        else if (dy_neg)
        begin
            dir.digit = dx_pos ? DIGIT_UP_RIGHT : DIGIT_UP_LEFT;
        end
        else
        begin
            dir.digit = dx_pos ? DIGIT_DOWN_RIGHT : DIGIT_DOWN_LEFT;
        end
    end

endmodule

[verif/swipe_checker.sv]
module swipe_checker
    import swd_pkg::*;
#(
    parameter int SLOTS = TOUCH_SLOTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [THR_W-1:0]          cfg_wr_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [IDX_W-1:0]          touch_index,
    input  logic                      first_of_frame,
    input  logic                      pressed,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [DIGIT_W-1:0]        keypad_digit,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the tracker state
    mode_t                      slot_mode [SLOTS];
    logic signed [COORD_W-1:0]  anchor_x [SLOTS];
    logic signed [COORD_W-1:0]  anchor_y [SLOTS];
    logic                       frame_done;
    logic [THR_W-1:0]           threshold;
    logic [DIGIT_W-1:0]         digit_queue [$];

    // Map a move onto one of the eight keypad sectors
    function automatic logic [DIGIT_W-1:0] heading(longint dx, longint dy);
        longint ax;
        longint ay;
        longint s;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        s  = (ax + ay) * (ax + ay);
        if (ax == 0 && ay == 0)
            return DIGIT_RIGHT;
        if (s < 2 * ax * ax)
            return (dx > 0) ? DIGIT_RIGHT : DIGIT_LEFT;
        if (s < 2 * ay * ay)
            return (dy < 0) ? DIGIT_UP : DIGIT_DOWN;
        if (dy < 0)
            return (dx > 0) ? DIGIT_UP_RIGHT : DIGIT_UP_LEFT;
        return (dx > 0) ? DIGIT_DOWN_RIGHT : DIGIT_DOWN_LEFT;
    endfunction

    // Advance one slot's tracker by one sample and return the digit it reports
    function automatic logic [DIGIT_W-1:0] advance_tracker(
        input logic [IDX_W-1:0]          idx,
        input logic                      first,
        input logic                      down,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        logic [DIGIT_W-1:0] digit;
        longint dx;
        longint dy;
        longint dist_sq;
        longint thr_sq;
        digit = DIGIT_NONE;
        if (first)
            frame_done = 1'b0;
        if (frame_done || int'(idx) >= SLOTS)
            return DIGIT_NONE;
        case (slot_mode[idx])
            MODE_TRACK:
            begin
                if (!down)
                    slot_mode[idx] = MODE_IDLE;
                else
                begin
                    dx      = longint'(x) - longint'(anchor_x[idx]);
                    dy      = longint'(y) - longint'(anchor_y[idx]);
                    dist_sq = dx * dx + dy * dy;
                    thr_sq  = longint'(threshold) * longint'(threshold);
                    if (dist_sq >= thr_sq)
                    begin
                        digit = heading(dx, dy);
                        slot_mode[idx] = MODE_USED;
                    end
                end
            end
            MODE_USED:
            begin
                if (!down)
                    slot_mode[idx] = MODE_IDLE;
            end
            default:
            begin
                // idle, and the unused code behaves as idle
                if (down)
                begin
                    anchor_x[idx]  = x;
                    anchor_y[idx]  = y;
                    slot_mode[idx] = MODE_TRACK;
                end
            end
        endcase
        if (digit != DIGIT_NONE)
            frame_done = 1'b1;
        return digit;
    endfunction

    // Compare outgoing words, then predict incoming ones
    always @(posedge clk or negedge rst_n)
    begin
        logic [DIGIT_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_mode[i] = MODE_IDLE;
            frame_done = 1'b0;
            threshold  = THR_RESET;
            digit_queue.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digit_queue.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected output word, keypad_digit %0d",
                                 $realtime, keypad_digit);
                    fail_count++;
                end
                else
                begin
                    want = digit_queue.pop_front();
                    if (keypad_digit !== want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: keypad_digit mismatch, expected %0d, got %0d",
                                     $realtime, want, keypad_digit);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (in_valid && in_ready)
                digit_queue.push_back(advance_tracker(touch_index, first_of_frame, pressed,
                                                      pos_x, pos_y));
            pending = digit_queue.size();
        end
    end

endmodule

[verif/tb_swipe_direction_detector_top.sv]
module tb_swipe_direction_detector_top
    import swd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [THR_W-1:0]          cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [IDX_W-1:0]          touch_index = '0;
    logic                      first_of_frame = 1'b0;
    logic                      pressed = 1'b0;
    logic signed [COORD_W-1:0] pos_x = '0;
    logic signed [COORD_W-1:0] pos_y = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [DIGIT_W-1:0]        keypad_digit;

    int fail_count;
    int pending_words;
    int words_sent = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    // Last position seen per slot, so moves stay near the start point
    logic signed [COORD_W-1:0] last_x [TOUCH_SLOTS_DEF];
    logic signed [COORD_W-1:0] last_y [TOUCH_SLOTS_DEF];

    // One move per direction: right, left, up, down, up-right, up-left, down-right, down-left
    int dir_dx [8] = '{40, -40, 0, 0, 30, -30, 30, -30};
    int dir_dy [8] = '{0, 0, -40, 40, -30, -30, 30, 30};

    swipe_direction_detector_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .touch_index    (touch_index),
        .first_of_frame (first_of_frame),
        .pressed        (pressed),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keypad_digit   (keypad_digit)
    );

    swipe_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .touch_index    (touch_index),
        .first_of_frame (first_of_frame),
        .pressed        (pressed),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keypad_digit   (keypad_digit),
        .fail_count     (fail_count),
        .pending        (pending_words)
    );

    always #10 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Stall the result side at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_length();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Present one sample and hold it until accepted; called at a rising edge
    task automatic send_word(
        input logic [IDX_W-1:0]          idx,
        input logic                      first,
        input logic                      down,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        int gap;
        gap = quiet ? 0 : gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        touch_index    <= idx;
        first_of_frame <= first;
        pressed        <= down;
        pos_x          <= x;
        pos_y          <= y;
        last_x[idx] = x;
        last_y[idx] = y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Hold off the sender until every expected word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Frames of random samples, mostly on a few slots moving near the threshold
    task automatic run_phase(input logic [THR_W-1:0] thr, input int count);
        int stop;
        int nsamp;
        int span;
        logic [IDX_W-1:0] idx;
        logic down;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        stop = words_sent + count;
        span = 2 * int'(thr) + 4;
        while (words_sent < stop)
        begin
            nsamp = $urandom_range(1, 5);
            for (int k = 0; k < nsamp; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    idx = IDX_W'($urandom_range(0, 3));
                else
                    idx = IDX_W'($urandom_range(0, 15));
                down = ($urandom_range(0, 99) < 80);
                if ($urandom_range(0, 99) < 90)
                begin
                    x = COORD_W'(int'(last_x[idx]) + int'($urandom_range(0, 2 * span)) - span);
                    y = COORD_W'(int'(last_y[idx]) + int'($urandom_range(0, 2 * span)) - span);
                end
                else
                begin
                    x = COORD_W'($urandom_range(0, 65535));
                    y = COORD_W'($urandom_range(0, 65535));
                end
                send_word(idx, (k == 0), down, x, y);
            end
        end
    endtask

    // Stimulus
    initial
    begin
        for (int i = 0; i < TOUCH_SLOTS_DEF; i++)
        begin
            last_x[i] = '0;
            last_y[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Press slots 0..7 at the origin, plus the corner, release and threshold slots
        for (int k = 0; k < 8; k++)
            send_word(IDX_W'(k), (k == 0), 1'b1, 16'sd0, 16'sd0);
        send_word(4'd9, 1'b0, 1'b1, 16'sh8000, 16'sh8000);
        send_word(4'd10, 1'b0, 1'b1, 16'sd7, 16'sd7);
        send_word(4'd11, 1'b0, 1'b1, 16'sd0, 16'sd0);

        // One swipe per direction, each in a frame of its own
        for (int k = 0; k < 8; k++)
            send_word(IDX_W'(k), 1'b1, 1'b1, COORD_W'(dir_dx[k]), COORD_W'(dir_dy[k]));
        // Frame already decided: this press must be dropped
        send_word(4'd8, 1'b0, 1'b1, 16'sd123, -16'sd45);
        // Full-scale diagonal move
        send_word(4'd9, 1'b1, 1'b1, 16'sd32767, 16'sd32767);
        // Release while tracking
        send_word(4'd10, 1'b1, 1'b0, 16'sd7, 16'sd7);
        // Just below, then exactly at the threshold
        send_word(4'd11, 1'b1, 1'b1, 16'sd31, 16'sd0);
        send_word(4'd11, 1'b0, 1'b1, 16'sd32, 16'sd0);
        drain();

        // Zero threshold: a move of nothing reports right
        write_threshold('0);
        send_word(4'd0, 1'b1, 1'b0, 16'sd5, 16'sd5);
        send_word(4'd0, 1'b0, 1'b1, 16'sd5, 16'sd5);
        send_word(4'd0, 1'b0, 1'b1, 16'sd5, 16'sd5);
        drain();

        write_threshold(12'd1);
        run_phase(12'd1, 320);
        drain();
        write_threshold(12'd4095);
        run_phase(12'd4095, 320);
        drain();
        begin
            logic [THR_W-1:0] thr;
            thr = THR_W'($urandom_range(2, 4094));
            write_threshold(thr);
            run_phase(thr, 320);
        end
        drain();
        quiet = 1'b1;
        write_threshold(THR_RESET);
        run_phase(THR_RESET, 320);
        drain();
        quiet = 1'b0;
        begin
            logic [THR_W-1:0] thr;
            thr = THR_W'($urandom_range(1, 200));
            write_threshold(thr);
            run_phase(thr, 320);
        end
        drain();
        write_threshold('0);
        run_phase('0, 320);
        drain();

        // Let any stray word show up before the verdict
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[swipe_direction_detector_top.f]
hw/rtl/swd_pkg.sv
hw/rtl/swd_start_mem.sv
hw/rtl/swd_classify.sv
hw/rtl/swipe_direction_detector_top.sv
verif/swipe_checker.sv
verif/tb_swipe_direction_detector_top.sv
